// File: rtl/hglt_pkg.sv
// Shared types and constants for the hashed group lock table.
// Used by the lock table top level; no dependencies.
package hglt_pkg;

	localparam int HomeW  = 9;
	localparam int FileW  = 15;
	localparam int GroupW = 31;
	localparam int HoldW  = 16;
	localparam int OwnerW = 15;
	localparam int StepW  = 10;

	localparam logic [1:0] ST_GRANT    = 2'd0;
	localparam logic [1:0] ST_WAIT     = 2'd1;
	localparam logic [1:0] ST_RELEASED = 2'd2;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic [HoldW-1:0] HOLD_WRITE    = 16'hFFFF;
	localparam logic [HoldW-1:0] HOLD_READ_MAX = 16'h7FFF;

	typedef struct packed {
		logic [HomeW-1:0]  home;
		logic [FileW-1:0]  file;
		logic [GroupW-1:0] group;
		logic [HoldW-1:0]  hold;
		logic [OwnerW-1:0] owner;
	} cell_entry_t;

	localparam int EntryW = $bits(cell_entry_t);

endpackage

// File: rtl/hglt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the cell table and the per-home active counts.
module hglt_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/hashed_group_lock_table_unit.sv
// Lock table top level: stream ports, probe sequencer, cell and count RAMs.
// Depends on hglt_pkg and hglt_ram.
// Acquire: home reads issue in the accept cycle, then one cell is probed per cycle;
// the result register loads on the last probe cycle (a bad home answers at the
// accept beat). Release: result loads at the accept beat; for a valid cell the
// table update holds the input off in S_REL_EVAL, then S_REL_CNT if it drops.
// One item at a time. Reset: asynchronous, then clearing all cells with no beats.
module hashed_group_lock_table_unit
	import hglt_pkg::*;
#(
	parameter int NUM_CELLS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// home_cell, file_ident, group_number, exclusive, owner_user, release_cell
	input  logic [79:0] s_tdata,
	// kind
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// granted_cell, probe_steps, zero pad
	output logic [23:0] m_tdata,
	// status
	output logic [1:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data
);

	localparam int AW  = $clog2(NUM_CELLS);
	localparam int CNW = $clog2(NUM_CELLS + 1);
	localparam int NW  = (CNW > HomeW) ? CNW : HomeW;

	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_PROBE    = 3'd2;
	localparam logic [2:0] S_REL_EVAL = 3'd3;
	localparam logic [2:0] S_REL_CNT  = 3'd4;

	logic [2:0]        state_q;
	logic [AW-1:0]     clr_q;
	logic [HomeW-1:0]  cfg_q;

	logic [HomeW-1:0]  home_q;
	logic [FileW-1:0]  file_q;
	logic [GroupW-1:0] group_q;
	logic              excl_q;
	logic [OwnerW-1:0] owner_q;
	logic [NW-1:0]     cur_q;
	logic [NW-1:0]     freec_q;
	logic [CNW-1:0]    active_q;
	logic [CNW-1:0]    base_cnt_q;
	logic [StepW-1:0]  steps_q;
	logic              first_q;
	logic              phase2_q;
	logic [NW-1:0]     rel_home_q;

	logic              mv_q;
	logic [1:0]        mst_q;
	logic [HomeW-1:0]  mcell_q;
	logic [StepW-1:0]  msteps_q;

	// input unpacking
	logic [HomeW-1:0]  in_home;
	logic [FileW-1:0]  in_file;
	logic [GroupW-1:0] in_group;
	logic              in_excl;
	logic [OwnerW-1:0] in_owner;
	logic [HomeW-1:0]  in_rel;
	assign in_home  = s_tdata[8:0];
	assign in_file  = s_tdata[23:9];
	assign in_group = s_tdata[54:24];
	assign in_excl  = s_tdata[55];
	assign in_owner = s_tdata[70:56];
	assign in_rel   = s_tdata[79:71];

	// memory ports
	logic              cell_we;
	logic [AW-1:0]     cell_waddr;
	cell_entry_t       cell_wdata;
	logic [AW-1:0]     cell_raddr;
	logic [EntryW-1:0] cell_rbits;
	cell_entry_t       d;
	logic              cnt_we;
	logic [AW-1:0]     cnt_waddr;
	logic [CNW-1:0]    cnt_wdata;
	logic [AW-1:0]     cnt_raddr;
	logic [CNW-1:0]    cnt_rd;

	assign d = cell_entry_t'(cell_rbits);

	hglt_ram #(.DEPTH(NUM_CELLS), .WIDTH(EntryW)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rbits)
	);

	hglt_ram #(.DEPTH(NUM_CELLS), .WIDTH(CNW)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rd)
	);

	// effective span, register clamped to 1..NUM_CELLS
	logic [NW-1:0] cfg_ext;
	logic [NW-1:0] span_w;
	always_comb begin
		cfg_ext = NW'(cfg_q);
		if (cfg_ext == '0) begin
			span_w = NW'(1);
		end else if (cfg_ext > NW'(NUM_CELLS)) begin
			span_w = NW'(NUM_CELLS);
		end else begin
			span_w = cfg_ext;
		end
	end

	logic          accept;
	logic [NW-1:0] in_home_ext;
	logic [NW-1:0] in_rel_ext;
	logic [NW-1:0] in_home_m1;
	logic [NW-1:0] in_rel_m1;
	logic          home_ok;
	logic          rel_ok;
	assign s_tready    = (state_q == S_IDLE) && (!mv_q || m_tready);
	assign accept      = s_tvalid && s_tready;
	assign in_home_ext = NW'(in_home);
	assign in_rel_ext  = NW'(in_rel);
	assign in_home_m1  = in_home_ext - NW'(1);
	assign in_rel_m1   = in_rel_ext - NW'(1);
	assign home_ok     = (in_home_ext != '0) && (in_home_ext <= span_w);
	assign rel_ok      = (in_rel_ext != '0) && (in_rel_ext <= NW'(NUM_CELLS));

	// probe step evaluation
	logic [NW-1:0]    home_ext;
	logic [NW-1:0]    home_m1;
	logic [NW-1:0]    cur_m1;
	logic [NW-1:0]    nxt;
	logic [CNW-1:0]   act;
	logic [CNW-1:0]   act_n;
	logic [CNW-1:0]   cnt_eff;
	logic [NW-1:0]    freec_n;
	logic [NW-1:0]    place_m1;
	logic [StepW-1:0] steps_n;
	logic             ph2;
	logic             is_mine;
	logic             is_free;
	logic             id_match;
	logic             p_done;
	logic             p_grant;
	logic             p_join;
	logic             p_place;
	logic             p_to_ph2;
	logic [NW-1:0]    p_cell;
	logic [NW-1:0]    dh_ext;
	logic [NW-1:0]    dh_m1;
	logic [NW-1:0]    rel_home_m1;
	logic             rel_drop;
	logic             res_load;

	always_comb begin
		home_ext = NW'(home_q);
		home_m1  = home_ext - NW'(1);
		cur_m1   = cur_q - NW'(1);
		nxt      = (cur_q >= span_w) ? NW'(1) : cur_q + NW'(1);
		act      = first_q ? cnt_rd : active_q;
		cnt_eff  = first_q ? cnt_rd : base_cnt_q;
		ph2      = phase2_q || (first_q && (cnt_rd == '0));
		steps_n  = steps_q + StepW'(1);
		is_mine  = (d.home == home_q);
		is_free  = (d.home == '0);
		id_match = (d.file == file_q) && (d.group == group_q);
		act_n    = is_mine ? act - CNW'(1) : act;
		freec_n  = (is_free && (freec_q == '0)) ? cur_q : freec_q;
		p_done   = 1'b0;
		p_grant  = 1'b0;
		p_join   = 1'b0;
		p_place  = 1'b0;
		p_to_ph2 = 1'b0;
		p_cell   = '0;
		if (!ph2) begin
			if (is_mine && id_match) begin
				p_done = 1'b1;
				if (!excl_q && (d.hold < HOLD_READ_MAX)) begin
					p_join  = 1'b1;
					p_grant = 1'b1;
					p_cell  = cur_q;
				end
			end else if (nxt == home_ext) begin
				p_done = 1'b1;
			end else if (act_n == '0) begin
				if (freec_n != '0) begin
					p_done  = 1'b1;
					p_place = 1'b1;
					p_grant = 1'b1;
					p_cell  = freec_n;
				end else begin
					p_to_ph2 = 1'b1;
				end
			end
		end else begin
			if (is_free) begin
				p_done  = 1'b1;
				p_place = 1'b1;
				p_grant = 1'b1;
				p_cell  = cur_q;
			end else if (nxt == home_ext) begin
				p_done = 1'b1;
			end
		end
		place_m1    = p_cell - NW'(1);
		dh_ext      = NW'(d.home);
		dh_m1       = dh_ext - NW'(1);
		rel_home_m1 = rel_home_q - NW'(1);
		rel_drop    = (d.hold == HOLD_WRITE) || (d.hold <= HoldW'(1));
	end

	// a new result beat loads this cycle
	assign res_load = (accept && ((s_tuser == KIND_RELEASE) || !home_ok))
	               || ((state_q == S_PROBE) && p_done);

	// memory port steering
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = cur_m1[AW-1:0];
		cell_wdata = d;
		cell_raddr = nxt[AW-1:0] - AW'(1);
		cnt_we     = 1'b0;
		cnt_waddr  = home_m1[AW-1:0];
		cnt_wdata  = cnt_eff + CNW'(1);
		cnt_raddr  = home_m1[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				cell_we    = 1'b1;
				cell_waddr = clr_q;
				cell_wdata = '0;
				cnt_we     = 1'b1;
				cnt_waddr  = clr_q;
				cnt_wdata  = '0;
			end
			S_IDLE: begin
				cell_raddr = (s_tuser == KIND_RELEASE) ? in_rel_m1[AW-1:0]
				                                       : in_home_m1[AW-1:0];
				cnt_raddr  = in_home_m1[AW-1:0];
			end
			S_PROBE: begin
				if (p_join) begin
					cell_we          = 1'b1;
					cell_wdata.hold  = d.hold + HoldW'(1);
					cell_wdata.owner = owner_q;
				end else if (p_place) begin
					cell_we          = 1'b1;
					cell_waddr       = place_m1[AW-1:0];
					cell_wdata.home  = home_q;
					cell_wdata.file  = file_q;
					cell_wdata.group = group_q;
					cell_wdata.hold  = excl_q ? HOLD_WRITE : HoldW'(1);
					cell_wdata.owner = owner_q;
					cnt_we           = 1'b1;
				end
			end
			S_REL_EVAL: begin
				cell_waddr = cur_m1[AW-1:0];
				cnt_raddr  = dh_m1[AW-1:0];
				if (d.home != '0) begin
					cell_we = 1'b1;
					if (rel_drop) begin
						cell_wdata.home = '0;
					end else begin
						cell_wdata.hold = d.hold - HoldW'(1);
					end
				end
			end
			S_REL_CNT: begin
				cnt_waddr = rel_home_m1[AW-1:0];
				cnt_wdata = cnt_rd - CNW'(1);
				cnt_we    = (cnt_rd != '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cfg_q   <= 9'd256;
			mv_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (mv_q && m_tready && !res_load) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == KIND_RELEASE) begin
							mv_q     <= 1'b1;
							mst_q    <= ST_RELEASED;
							mcell_q  <= '0;
							msteps_q <= '0;
							if (rel_ok) begin
								state_q <= S_REL_EVAL;
							end
						end else if (!home_ok) begin
							mv_q     <= 1'b1;
							mst_q    <= ST_WAIT;
							mcell_q  <= '0;
							msteps_q <= '0;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (p_done) begin
						mv_q     <= 1'b1;
						mst_q    <= p_grant ? ST_GRANT : ST_WAIT;
						mcell_q  <= p_cell[HomeW-1:0];
						msteps_q <= steps_n;
						state_q  <= S_IDLE;
					end
				end
				S_REL_EVAL: begin
					if ((d.home != '0) && rel_drop && (dh_ext <= NW'(NUM_CELLS))) begin
						state_q <= S_REL_CNT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_REL_CNT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			home_q   <= in_home;
			file_q   <= in_file;
			group_q  <= in_group;
			excl_q   <= in_excl;
			owner_q  <= in_owner;
			cur_q    <= (s_tuser == KIND_RELEASE) ? in_rel_ext : in_home_ext;
			freec_q  <= '0;
			steps_q  <= '0;
			first_q  <= 1'b1;
			phase2_q <= 1'b0;
		end else if (state_q == S_PROBE) begin
			cur_q    <= nxt;
			steps_q  <= steps_n;
			first_q  <= 1'b0;
			active_q <= act_n;
			freec_q  <= freec_n;
			if (first_q) begin
				base_cnt_q <= cnt_rd;
			end
			if (ph2 || p_to_ph2) begin
				phase2_q <= 1'b1;
			end
		end
		if (state_q == S_REL_EVAL) begin
			rel_home_q <= dh_ext;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = mst_q;
	assign m_tdata  = {5'd0, msteps_q, mcell_q};

endmodule

// File: tb/hglt_lock_checker.sv
`timescale 1ns / 100ps
// Lock table checker: predicts each lock result from the accepted request beats
// and compares the result beats field by field. Depends on hglt_pkg.
module hglt_lock_checker
	import hglt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data,
	output int          failures,
	output int          outstanding
);
	localparam int Cells = 256;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] slot;
		logic [9:0] steps;
	} lock_result_t;

	lock_result_t result_q[$];

	logic [8:0]  span_reg;
	logic [8:0]  slot_home [Cells];
	logic [8:0]  home_live [Cells];
	logic [14:0] slot_file [Cells];
	logic [30:0] slot_group[Cells];
	logic [15:0] slot_hold [Cells];
	logic [14:0] slot_owner[Cells];

	assign outstanding = result_q.size();

	function automatic lock_result_t mk(logic [1:0] st, int c, int n);
		lock_result_t r;
		r.status = st;
		r.slot   = c[8:0];
		r.steps  = n[9:0];
		return r;
	endfunction

	function automatic lock_result_t lock_step(logic [79:0] d, logic k);
		int span, home, scan, freec, steps, active, c, rel, h;
		logic [14:0] file, owner;
		logic [30:0] grp;
		logic excl;
		span  = (span_reg < 1) ? 1 : (span_reg > Cells) ? Cells : int'(span_reg);
		home  = int'(d[8:0]);
		file  = d[23:9];
		grp   = d[54:24];
		excl  = d[55];
		owner = d[70:56];
		rel   = int'(d[79:71]);
		freec = 0;
		steps = 0;
		if (k == KIND_RELEASE) begin
			if (rel >= 1 && rel <= Cells && slot_home[rel-1] != 0) begin
				c = rel - 1;
				if (slot_hold[c] == HOLD_WRITE || slot_hold[c] <= 1) begin
					h = int'(slot_home[c]);
					slot_home[c] = '0;
					if (home_live[h-1] > 0) home_live[h-1]--;
				end else begin
					slot_hold[c]--;
				end
			end
			return mk(ST_RELEASED, 0, 0);
		end
		if (home < 1 || home > span) return mk(ST_WAIT, 0, 0);
		scan = home;
		active = int'(home_live[home-1]);
		while (active > 0) begin
			c = scan - 1;
			steps++;
			if (slot_home[c] == home) begin
				if (slot_file[c] == file && slot_group[c] == grp) begin
					if (!excl && slot_hold[c] < HOLD_READ_MAX) begin
						slot_hold[c]++;
						slot_owner[c] = owner;
						return mk(ST_GRANT, scan, steps);
					end
					return mk(ST_WAIT, 0, steps);
				end
				active--;
			end else if (slot_home[c] == 0 && freec == 0) begin
				freec = scan;
			end
			scan = (scan >= span) ? 1 : scan + 1;
			if (scan == home) return mk(ST_WAIT, 0, steps);
		end
		while (freec == 0) begin
			steps++;
			if (slot_home[scan-1] == 0) begin
				freec = scan;
				break;
			end
			scan = (scan >= span) ? 1 : scan + 1;
			if (scan == home) return mk(ST_WAIT, 0, steps);
		end
		c = freec - 1;
		slot_home[c]  = 9'(home);
		slot_owner[c] = owner;
		slot_file[c]  = file;
		slot_group[c] = grp;
		slot_hold[c]  = excl ? HOLD_WRITE : 16'd1;
		home_live[home-1]++;
		return mk(ST_GRANT, freec, steps);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lock_result_t want;
		int errs;
		if (!arst_n) begin
			failures <= 0;
			span_reg <= 9'd256;
			result_q.delete();
			for (int i = 0; i < Cells; i++) begin
				slot_home[i]  = '0;
				home_live[i]  = '0;
				slot_file[i]  = '0;
				slot_group[i] = '0;
				slot_hold[i]  = '0;
				slot_owner[i] = '0;
			end
		end else begin
			errs = 0;
			if (cfg_wr_en) span_reg <= cfg_wr_data;
			if (s_tvalid && s_tready) result_q.push_back(lock_step(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("result beat with no request pending");
					errs++;
				end else begin
					want = result_q.pop_front();
					if (m_tuser != want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errs++;
					end
					if (m_tdata[8:0] != want.slot) begin
						$error("granted_cell: expected %0d, got %0d", want.slot, m_tdata[8:0]);
						errs++;
					end
					if (m_tdata[18:9] != want.steps) begin
						$error("probe_steps: expected %0d, got %0d", want.steps,
							m_tdata[18:9]);
						errs++;
					end
				end
			end
			if (errs != 0) failures <= failures + errs;
		end
	end
endmodule

// File: tb/tb_hashed_group_lock_table_unit.sv
`timescale 1ns / 100ps
// Testbench top for the lock table: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on hglt_pkg and hglt_lock_checker.
module tb_hashed_group_lock_table_unit;
	import hglt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [79:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en;
	logic [8:0]  cfg_wr_data;
	int          failures, outstanding;
	int          span;
	int          burst_left;
	longint      cycles;

	hashed_group_lock_table_unit u_top (.*);

	hglt_lock_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// result side stalls: m_tready follows a randomly redrawn mode out of four
	initial begin
		int mode;
		m_tready = 0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat (64) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 1500000) begin
				$display("hashed_group_lock_table_unit: mismatch");
				$finish;
			end
		end
	end

	// hold valid across bursts; drop it only for a gap
	task automatic send(logic k, logic [8:0] home, logic [14:0] file, logic [30:0] grp,
			logic excl, logic [14:0] owner, logic [8:0] rel);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {rel, owner, excl, grp, file, home};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic acq(int home, int file, int grp, int excl);
		send(KIND_ACQUIRE, home[8:0], file[14:0], grp[30:0], excl[0], 15'($urandom),
			9'($urandom));
	endtask

	task automatic rel(int c);
		send(KIND_RELEASE, 9'($urandom), 15'($urandom), 31'($urandom), 1'($urandom),
			15'($urandom), c[8:0]);
	endtask

	// wait for the table to drain, then write the cell count
	task automatic set_span(int v);
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v[8:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		span = (v < 1) ? 1 : (v > 256) ? 256 : v;
		@(posedge clk);
	endtask

	task automatic random_item();
		int home, file, grp;
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 9))
				0: home = $urandom_range(0, 511);
				1: home = 0;
				default: home = $urandom_range(1, span);
			endcase
			if ($urandom_range(0, 4) == 0) begin
				file = $urandom;
				grp  = $urandom;
			end else begin
				file = $urandom_range(0, 3);
				grp  = $urandom_range(0, 3);
			end
			acq(home, file, grp, $urandom);
		end else if ($urandom_range(0, 7) == 0) begin
			rel($urandom_range(0, 511));
		end else begin
			rel($urandom_range(1, span));
		end
	endtask

	initial begin
		int settings[10] = '{0, 1, 2, 3, 5, 8, 16, 300, 255, 256};
		burst_left = 0;
		span = 256;
		arst_n = 0;
		s_tvalid = 0;
		s_tuser = 0;
		s_tdata = '0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		set_span(256);
		acq(0, 1, 1, 0);
		acq(257, 1, 1, 0);
		acq(1, 5, 9, 0);
		acq(1, 5, 9, 0);
		acq(1, 5, 9, 1);
		rel(1);
		rel(1);
		rel(1);
		rel(0);
		rel(511);
		acq(256, 32767, 32'h7FFFFFFF, 1);
		acq(256, 0, 0, 1);
		acq(256, 32767, 32'h7FFFFFFF, 0);
		rel(256);
		rel(1);
		// stack read locks on one cell; they stay behind for the later phases
		for (int i = 0; i < 6; i++) acq(256, 7, 7, 0);
		acq(256, 7, 7, 1);

		set_span(2);
		acq(1, 1, 1, 1);
		acq(2, 2, 2, 0);
		acq(1, 3, 3, 0);
		rel(1);
		rel(2);

		foreach (settings[p]) begin
			set_span(settings[p]);
			for (int i = 0; i < 52; i++) begin
				random_item();
				// let the table drain once mid-phase
				if (p == 4 && i == 20) begin
					s_tvalid <= 1'b0;
					burst_left = 0;
					@(posedge clk);
					wait (outstanding == 0);
					@(posedge clk);
				end
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		wait (outstanding == 0);
		repeat (40) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("hashed_group_lock_table_unit: match");
		end else begin
			$display("hashed_group_lock_table_unit: mismatch");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/hglt_pkg.sv
rtl/hglt_ram.sv
rtl/hashed_group_lock_table_unit.sv
tb/hglt_lock_checker.sv
tb/tb_hashed_group_lock_table_unit.sv
